// ===== src/dmcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// dmcpu_pkg
// Shared constants, codes, types and the word split helper of the decimal
// microcoded CPU.
// ----------------------------------------------------------------------------
`default_nettype none

package dmcpu_pkg;

	// Machine geometry.
	localparam int LOW_MAX   = 999;
	localparam int HIGH_MAX  = 19;
	localparam int MICRO_MAX = 199;
	localparam int WORD_BASE = 1000;
	localparam int WORD_TOP  = HIGH_MAX * WORD_BASE + LOW_MAX;
	localparam int ENTRY_TOP = 1023;

	localparam int RAM_DEPTH = LOW_MAX + 1;
	localparam int US_DEPTH  = MICRO_MAX + 1;
	localparam int OPT_DEPTH = HIGH_MAX + 1;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int US_AW     = $clog2(US_DEPTH);
	localparam int OPT_AW    = $clog2(OPT_DEPTH);

	// Field widths.
	localparam int WORD_W  = 15;
	localparam int ADDR_W  = 10;
	localparam int ENTRY_W = 10;
	localparam int HI_W    = 5;

	// Reciprocal of the word base for the hi/lo split.
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BASE;
	localparam int PROD_W      = WORD_W + RECIP_SHIFT - 9;

	// Item operations, carried in tuser.
	typedef enum logic [2:0] {
		OP_STEP       = 3'd0,
		OP_LOAD_RAM   = 3'd1,
		OP_LOAD_MICRO = 3'd2,
		OP_LOAD_OPTAB = 3'd3,
		OP_READ_RAM   = 3'd4
	} op_t;

	// Micro-operation codes held in the microcode store.
	typedef enum logic [ENTRY_W-1:0] {
		UOP_NOP      = 10'd0,
		UOP_DB_RAM   = 10'd1,
		UOP_RAM_DB   = 10'd2,
		UOP_DB_INS   = 10'd3,
		UOP_INS_AB   = 10'd4,
		UOP_INS_MC   = 10'd5,
		UOP_MC_ZERO  = 10'd7,
		UOP_PC_AB    = 10'd8,
		UOP_PC_INC   = 10'd9,
		UOP_PC_INC_Z = 10'd10,
		UOP_INS_PC   = 10'd11,
		UOP_ACC_CLR  = 10'd12,
		UOP_ACC_ADD  = 10'd13,
		UOP_ACC_SUB  = 10'd14,
		UOP_ACC_DB   = 10'd15,
		UOP_ACC_INC  = 10'd16,
		UOP_ACC_DEC  = 10'd17,
		UOP_DB_ACC   = 10'd18,
		UOP_STOP     = 10'd19,
		UOP_INS_DB   = 10'd20,
		UOP_MUR_ADDR = 10'd21,
		UOP_MUR_OP   = 10'd22,
		UOP_MUR_MC   = 10'd23,
		UOP_IOMAP    = 10'd24
	} uop_t;

	// Result item, packed from the lowest bit up as halted first.
	typedef struct packed {
		logic [2:0]        pad;
		logic [WORD_W-1:0] read_data;
		logic [WORD_W-1:0] data_value;
		logic [ADDR_W-1:0] address_value;
		logic [ADDR_W-1:0] micro_address;
		logic [WORD_W-1:0] acc_value;
		logic [ADDR_W-1:0] pc_value;
		logic              error;
		logic              halted;
	} res_t;

	// Hi and lo parts of a word.
	typedef struct packed {
		logic [5:0]        hi;
		logic [ADDR_W-1:0] lo;
	} split_t;

	// Splits a word by the word base: reciprocal estimate, then one correction.
	function automatic split_t word_split(input logic [WORD_W-1:0] w);
		logic [PROD_W-1:0] prod;
		logic [5:0]        q;
		logic [15:0]       qm;
		logic [15:0]       r;
		split_t            s;
		prod = PROD_W'(w) * PROD_W'(RECIP);
		q    = prod[PROD_W-1:RECIP_SHIFT];
		qm   = 16'(q) * 16'(WORD_BASE);
		r    = 16'(w) - qm;
		if (r >= 16'(WORD_BASE)) begin
			q = q + 6'd1;
			r = r - 16'(WORD_BASE);
		end
		s.hi = q;
		s.lo = r[ADDR_W-1:0];
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== src/decimal_microcoded_cpu_step.sv =====
// ----------------------------------------------------------------------------
// decimal_microcoded_cpu_step
// Each input item is handled as follows: in the cycle it is accepted the
// microcode store is read at the micro PC and the RAM at the address bus (or
// at the item address for a read), and in the execute cycle the micro-op runs,
// the registers and memories are written and the result item is loaded into
// the output register. One item is in execution at a time, so the input takes
// no new item until the one held has executed; the pair of synchronous memory
// ports sets this limit. A result waiting in the output register does not stop
// the next item from being accepted, only its execution. After reset a
// clearing pass zeroes the RAM and the microcode store, and no item is
// accepted during it.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_microcoded_cpu_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // address[9:0], value[24:10], zero pad
	input  wire logic [2:0]  s_axis_tuser,  // operation[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata   // halted, error, pc_value[11:2],
	                                        // acc_value[26:12],
	                                        // micro_address[36:27],
	                                        // address_value[46:37],
	                                        // data_value[61:47],
	                                        // read_data[76:62], zero pad
);

	localparam int WW = dmcpu_pkg::WORD_W;
	localparam int AW = dmcpu_pkg::ADDR_W;
	localparam int EW = dmcpu_pkg::ENTRY_W;

	// Memories.
	logic [WW-1:0] ram [dmcpu_pkg::RAM_DEPTH];
	logic [EW-1:0] ustore [dmcpu_pkg::US_DEPTH];

	// Architectural registers.
	logic [EW-1:0]               optab_q [dmcpu_pkg::OPT_DEPTH];
	logic [dmcpu_pkg::HI_W-1:0]  ihi_q;
	logic [AW-1:0]               ilo_q;
	logic [AW-1:0]               pc_q;
	logic [AW-1:0]               mpc_q;
	logic [WW-1:0]               acc_q;
	logic [AW-1:0]               ab_q;
	logic [WW-1:0]               db_q;
	logic [AW-1:0]               ua_q;
	logic [EW-1:0]               uo_q;
	logic [dmcpu_pkg::HI_W-1:0]  uc_q;
	logic                        halt_q;
	logic                        err_q;

	// Clearing pass.
	logic                        clr_active_q;
	logic [dmcpu_pkg::RAM_AW-1:0] clr_cnt_q;

	// Execute stage.
	logic          valid_s1;
	logic [2:0]    op_s1;
	logic [AW-1:0] addr_s1;
	logic [WW-1:0] value_s1;
	logic [WW-1:0] ram_rd_s1;
	logic [EW-1:0] us_rd_s1;

	// Output register.
	logic                 out_valid_q;
	dmcpu_pkg::res_t      out_data_q;

	logic                 accept;
	logic                 exec;
	logic [AW-1:0]        in_addr;
	logic [WW-1:0]        in_value;
	logic [dmcpu_pkg::RAM_AW-1:0] ram_raddr;
	logic [dmcpu_pkg::US_AW-1:0]  us_raddr;

	// Next values and write requests from the execute stage.
	logic [dmcpu_pkg::HI_W-1:0]  ihi_d;
	logic [AW-1:0]               ilo_d;
	logic [AW-1:0]               pc_d;
	logic [AW-1:0]               mpc_d;
	logic [WW-1:0]               acc_d;
	logic [AW-1:0]               ab_d;
	logic [WW-1:0]               db_d;
	logic [AW-1:0]               ua_d;
	logic [EW-1:0]               uo_d;
	logic [dmcpu_pkg::HI_W-1:0]  uc_d;
	logic                        halt_d;
	logic                        err_d;
	logic [WW-1:0]               rd_d;
	logic                        ram_we;
	logic [dmcpu_pkg::RAM_AW-1:0] ram_wa;
	logic [WW-1:0]               ram_wd;
	logic                        us_we;
	logic [dmcpu_pkg::US_AW-1:0] us_wa;
	logic [EW-1:0]               us_wd;
	logic                        opt_we;
	logic [dmcpu_pkg::OPT_AW-1:0] opt_wa;
	logic [EW-1:0]               opt_wd;
	logic [AW-1:0]               next_mpc;
	logic [15:0]                 sum;
	dmcpu_pkg::split_t           db_split;
	dmcpu_pkg::res_t             res;

	assign in_addr  = s_axis_tdata[AW-1:0];
	assign in_value = s_axis_tdata[AW+WW-1:AW];

	// One item in execution; accesses to the memories never overlap because
	// the execute cycle and the accept cycle are never the same.
	assign s_axis_tready = !valid_s1 && !clr_active_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign exec          = valid_s1 && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Read addresses, kept inside the stores.
	always_comb begin
		if (s_axis_tuser == dmcpu_pkg::OP_STEP) begin
			ram_raddr = ab_q[dmcpu_pkg::RAM_AW-1:0];
		end else if (in_addr <= dmcpu_pkg::LOW_MAX) begin
			ram_raddr = in_addr[dmcpu_pkg::RAM_AW-1:0];
		end else begin
			ram_raddr = '0;
		end
		if (mpc_q <= dmcpu_pkg::MICRO_MAX) begin
			us_raddr = mpc_q[dmcpu_pkg::US_AW-1:0];
		end else begin
			us_raddr = '0;
		end
	end

	// RAM: clearing pass, then one write port and one registered read.
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			ram[clr_cnt_q] <= '0;
		end else if (exec && ram_we) begin
			ram[ram_wa] <= ram_wd;
		end
		if (accept) begin
			ram_rd_s1 <= ram[ram_raddr];
		end
	end

	// Microcode store: cleared in the same pass over its smaller range.
	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			if (clr_cnt_q < dmcpu_pkg::RAM_AW'(dmcpu_pkg::US_DEPTH)) begin
				ustore[clr_cnt_q[dmcpu_pkg::US_AW-1:0]] <= '0;
			end
		end else if (exec && us_we) begin
			ustore[us_wa] <= us_wd;
		end
		if (accept) begin
			us_rd_s1 <= ustore[us_raddr];
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == dmcpu_pkg::RAM_AW'(dmcpu_pkg::RAM_DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Execute stage valid and item payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= s_axis_tuser;
			addr_s1  <= in_addr;
			value_s1 <= in_value;
		end
	end

	assign db_split = dmcpu_pkg::word_split(db_q);

	// Micro-op execution and load handling.
	always_comb begin
		ihi_d    = ihi_q;
		ilo_d    = ilo_q;
		pc_d     = pc_q;
		mpc_d    = mpc_q;
		acc_d    = acc_q;
		ab_d     = ab_q;
		db_d     = db_q;
		ua_d     = ua_q;
		uo_d     = uo_q;
		uc_d     = uc_q;
		halt_d   = halt_q;
		err_d    = err_q;
		rd_d     = '0;
		ram_we   = 1'b0;
		ram_wa   = ab_q[dmcpu_pkg::RAM_AW-1:0];
		ram_wd   = db_q;
		us_we    = 1'b0;
		us_wa    = ua_q[dmcpu_pkg::US_AW-1:0];
		us_wd    = uo_q;
		opt_we   = 1'b0;
		opt_wa   = uc_q[dmcpu_pkg::OPT_AW-1:0];
		opt_wd   = ua_q;
		next_mpc = mpc_q + 1'b1;
		sum      = '0;
		case (op_s1)
			dmcpu_pkg::OP_STEP: begin
				if (!halt_q && !err_q) begin
					if (mpc_q > dmcpu_pkg::MICRO_MAX) begin
						err_d = 1'b1;
					end else begin
						mpc_d = next_mpc;
						case (us_rd_s1)
							dmcpu_pkg::UOP_NOP: begin
							end
							dmcpu_pkg::UOP_DB_RAM: begin
								ram_we = (ab_q <= dmcpu_pkg::LOW_MAX);
							end
							dmcpu_pkg::UOP_RAM_DB: begin
								db_d = ram_rd_s1;
							end
							dmcpu_pkg::UOP_DB_INS: begin
								ihi_d = db_split.hi[dmcpu_pkg::HI_W-1:0];
								ilo_d = db_split.lo;
							end
							dmcpu_pkg::UOP_INS_AB: begin
								ab_d = ilo_q;
							end
							dmcpu_pkg::UOP_INS_MC: begin
								if (ihi_q <= dmcpu_pkg::HIGH_MAX) begin
									mpc_d = optab_q[ihi_q[dmcpu_pkg::OPT_AW-1:0]];
								end else begin
									mpc_d = '0;
								end
							end
							dmcpu_pkg::UOP_MC_ZERO: begin
								mpc_d = '0;
							end
							dmcpu_pkg::UOP_PC_AB: begin
								ab_d = pc_q;
							end
							dmcpu_pkg::UOP_PC_INC: begin
								pc_d = (pc_q == AW'(dmcpu_pkg::LOW_MAX)) ? '0 : pc_q + 1'b1;
							end
							dmcpu_pkg::UOP_PC_INC_Z: begin
								if (acc_q == '0) begin
									pc_d = (pc_q == AW'(dmcpu_pkg::LOW_MAX)) ? '0 :
										pc_q + 1'b1;
								end
							end
							dmcpu_pkg::UOP_INS_PC: begin
								pc_d = ilo_q;
							end
							dmcpu_pkg::UOP_ACC_CLR: begin
								acc_d = '0;
							end
							dmcpu_pkg::UOP_ACC_ADD: begin
								sum   = {1'b0, acc_q} + {1'b0, db_q};
								acc_d = (sum > 16'(dmcpu_pkg::WORD_TOP)) ?
									WW'(dmcpu_pkg::WORD_TOP) : sum[WW-1:0];
							end
							dmcpu_pkg::UOP_ACC_SUB: begin
								acc_d = (db_q > acc_q) ? WW'(dmcpu_pkg::WORD_TOP) :
									acc_q - db_q;
							end
							dmcpu_pkg::UOP_ACC_DB: begin
								db_d = acc_q;
							end
							dmcpu_pkg::UOP_ACC_INC: begin
								sum   = {1'b0, acc_q} + 16'd1;
								acc_d = (sum > 16'(dmcpu_pkg::WORD_TOP)) ?
									WW'(dmcpu_pkg::WORD_TOP) : sum[WW-1:0];
							end
							dmcpu_pkg::UOP_ACC_DEC: begin
								acc_d = (acc_q == '0) ? WW'(dmcpu_pkg::WORD_TOP) :
									acc_q - 1'b1;
							end
							dmcpu_pkg::UOP_DB_ACC: begin
								acc_d = (db_q > WW'(dmcpu_pkg::WORD_TOP)) ?
									WW'(dmcpu_pkg::WORD_TOP) : db_q;
							end
							dmcpu_pkg::UOP_STOP: begin
								halt_d = 1'b1;
							end
							dmcpu_pkg::UOP_INS_DB: begin
								db_d = WW'(ilo_q);
							end
							dmcpu_pkg::UOP_MUR_ADDR: begin
								ua_d = ilo_q;
							end
							dmcpu_pkg::UOP_MUR_OP: begin
								uo_d = ilo_q;
								uc_d = ihi_q;
							end
							dmcpu_pkg::UOP_MUR_MC: begin
								// An update op of LOW_MAX means "leave the store alone".
								if (uo_q != EW'(dmcpu_pkg::LOW_MAX)) begin
									if (ua_q <= dmcpu_pkg::MICRO_MAX) begin
										us_we = 1'b1;
									end else begin
										err_d = 1'b1;
									end
								end
								opt_we = (uc_q != '0) && (uc_q <= dmcpu_pkg::HIGH_MAX);
								ua_d   = '0;
								uo_d   = '0;
								uc_d   = '0;
							end
							dmcpu_pkg::UOP_IOMAP: begin
							end
							default: begin
								// Unknown micro-op: stop with the micro PC left in place.
								err_d = 1'b1;
								mpc_d = mpc_q;
							end
						endcase
					end
				end
			end
			dmcpu_pkg::OP_LOAD_RAM: begin
				ram_we = (addr_s1 <= dmcpu_pkg::LOW_MAX);
				ram_wa = addr_s1[dmcpu_pkg::RAM_AW-1:0];
				ram_wd = (value_s1 > WW'(dmcpu_pkg::WORD_TOP)) ?
					WW'(dmcpu_pkg::WORD_TOP) : value_s1;
			end
			dmcpu_pkg::OP_LOAD_MICRO: begin
				us_we = (addr_s1 <= dmcpu_pkg::MICRO_MAX);
				us_wa = addr_s1[dmcpu_pkg::US_AW-1:0];
				us_wd = (value_s1 > WW'(dmcpu_pkg::ENTRY_TOP)) ?
					EW'(dmcpu_pkg::ENTRY_TOP) : value_s1[EW-1:0];
			end
			dmcpu_pkg::OP_LOAD_OPTAB: begin
				opt_we = (addr_s1 <= dmcpu_pkg::HIGH_MAX);
				opt_wa = addr_s1[dmcpu_pkg::OPT_AW-1:0];
				opt_wd = (value_s1 > WW'(dmcpu_pkg::ENTRY_TOP)) ?
					EW'(dmcpu_pkg::ENTRY_TOP) : value_s1[EW-1:0];
			end
			dmcpu_pkg::OP_READ_RAM: begin
				rd_d = (addr_s1 <= dmcpu_pkg::LOW_MAX) ? ram_rd_s1 : '0;
			end
			default: begin
			end
		endcase
	end

	// Result item shows the state after the item.
	always_comb begin
		res               = '0;
		res.halted        = halt_d;
		res.error         = err_d;
		res.pc_value      = pc_d;
		res.acc_value     = acc_d;
		res.micro_address = mpc_d;
		res.address_value = ab_d;
		res.data_value    = db_d;
		res.read_data     = rd_d;
	end

	// Architectural registers, updated in the execute cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ihi_q  <= '0;
			ilo_q  <= '0;
			pc_q   <= '0;
			mpc_q  <= '0;
			acc_q  <= '0;
			ab_q   <= '0;
			db_q   <= '0;
			ua_q   <= '0;
			uo_q   <= '0;
			uc_q   <= '0;
			halt_q <= 1'b0;
			err_q  <= 1'b0;
			for (int i = 0; i < dmcpu_pkg::OPT_DEPTH; i++) begin
				optab_q[i] <= '0;
			end
		end else if (exec) begin
			ihi_q  <= ihi_d;
			ilo_q  <= ilo_d;
			pc_q   <= pc_d;
			mpc_q  <= mpc_d;
			acc_q  <= acc_d;
			ab_q   <= ab_d;
			db_q   <= db_d;
			ua_q   <= ua_d;
			uo_q   <= uo_d;
			uc_q   <= uc_d;
			halt_q <= halt_d;
			err_q  <= err_d;
			if (opt_we) begin
				optab_q[opt_wa] <= opt_wd;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_data_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== src/dmcpu_checker.sv =====
// ----------------------------------------------------------------------------
// dmcpu_checker
// Port-level checks of the decimal microcoded CPU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmcpu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic [2:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;
	logic       halt_seen_q;
	logic       err_seen_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Items accepted but not yet delivered, and sticky flags seen so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			halt_seen_q <= 1'b0;
			err_seen_q  <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (out_acc) begin
				halt_seen_q <= halt_seen_q || m_axis_tdata[0];
				err_seen_q  <= err_seen_q || m_axis_tdata[1];
			end
		end
	end

	// Only one item executes at a time.
	a_one_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("item accepted while the previous one executes");

	// A result always belongs to an accepted item.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pend_q != 2'd0))
		else $error("result item without an accepted item");

	// Halt and error stay set once reported.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> ((m_axis_tdata[0] || !halt_seen_q) && (m_axis_tdata[1] || !err_seen_q)))
		else $error("halt or error flag cleared without reset");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result item changed");

endmodule

bind decimal_microcoded_cpu_step dmcpu_checker u_dmcpu_checker (.*);

`default_nettype wire
